### rtl/assert_macros.svh
// assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

`define ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition");

`else

`define ASSERT_CLK(label, clk, rst, prop)

`define ASSERT_NEVER(label, clk, rst, expr)

`endif

`endif

### rtl/bu2xm_pkg.sv
`default_nettype none

package bu2xm_pkg;

   localparam int COORD_W = 10;
   localparam int CHAN_W  = 8;
   localparam int PIX_W   = 3 * CHAN_W;
   localparam int ACC_W   = CHAN_W + 4;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_SRC_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_HEIGHT = 2'd1;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_READ  = 1'b1;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_C    = 6'b000010,
      ST_RN   = 6'b000100,
      ST_CN   = 6'b001000,
      ST_D    = 6'b010000,
      ST_LAST = 6'b100000
   } state_type;

endpackage

`default_nettype wire

### rtl/bu2xm_ram.sv
`default_nettype none

module bu2xm_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 262144
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/bilinear_upscale_2x_mirror.sv
// read word: result strobe after states C, RN, CN, D and LAST, busy until then, next word taken
//   at the edge ending the strobe, one frame memory read per neighbor
// read word outside the doubled image: result strobe in the cycle after acceptance, no occupancy
// write word: no result; the receiver cannot stall, results are strobed once
// synchronous reset clears control and restores both size registers; frame memory is not
//   cleared, its contents are undefined until written
`default_nettype none

module bilinear_upscale_2x_mirror
   import bu2xm_pkg::*;
#(
   parameter int MAX_WIDTH  = 512,
   parameter int MAX_HEIGHT = 512
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output      logic                 busy,
   input  wire logic                 req_command,
   input  wire logic [COORD_W-1:0]   req_row,
   input  wire logic [COORD_W-1:0]   req_col,
   input  wire logic [CHAN_W-1:0]    req_red_in,
   input  wire logic [CHAN_W-1:0]    req_green_in,
   input  wire logic [CHAN_W-1:0]    req_blue_in,
   output      logic                 rsp_valid,
   output      logic [CHAN_W-1:0]    rsp_red_out,
   output      logic [CHAN_W-1:0]    rsp_green_out,
   output      logic [CHAN_W-1:0]    rsp_blue_out,
   output      logic                 rsp_coord_error,
   input  wire logic                 csr_valid,
   output      logic                 csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [COORD_W-1:0]   csr_data
);

   localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam logic [COORD_W-1:0] WIDTH_RST  = COORD_W'(MAX_WIDTH < 512 ? MAX_WIDTH : 512);
   localparam logic [COORD_W-1:0] HEIGHT_RST = COORD_W'(MAX_HEIGHT < 512 ? MAX_HEIGHT : 512);

   function automatic logic [COORD_W-1:0] nbr_index(input logic [COORD_W-1:0] t,
                                                    input logic [COORD_W-1:0] n);
      logic [COORD_W-1:0] k;
      k = {1'b0, t[COORD_W-1:1]};
      if (!t[0]) begin
         nbr_index = (k == '0) ? COORD_W'(1) : k - COORD_W'(1);
      end else begin
         nbr_index = ({1'b0, k} + (COORD_W+1)'(1) >= {1'b0, n}) ? n - COORD_W'(1)
                                                                : k + COORD_W'(1);
      end
   endfunction

   function automatic logic [COORD_W-1:0] clamp_dim(input logic [COORD_W-1:0] v,
                                                    input int maxv);
      if (v < COORD_W'(2)) begin
         clamp_dim = COORD_W'(2);
      end else if (32'(v) > maxv) begin
         clamp_dim = COORD_W'(maxv);
      end else begin
         clamp_dim = v;
      end
   endfunction

   state_type state_ff, state_in;

   logic [COORD_W-1:0] src_width_ff, src_height_ff;
   logic [COORD_W-1:0] kr_ff, kc_ff, nr_ff, nc_ff;
   logic [COORD_W-1:0] kr_in, kc_in, nr_in, nc_in;
   logic [ACC_W-1:0]   acc_ff [3];
   logic [ACC_W-1:0]   acc_in [3];
   logic [CHAN_W-1:0]  out_ff [3];
   logic [CHAN_W-1:0]  out_in [3];
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_err_ff, rsp_err_in;

   logic               accept, rd_accept, wr_ok, coord_bad;
   logic [COORD_W-1:0] rd_row, rd_col;
   logic [ADDR_W-1:0]  rd_addr, wr_addr;
   logic [PIX_W-1:0]   rd_pix;
   logic [CHAN_W-1:0]  chan [3];

   assign accept    = start && !busy;
   assign coord_bad = ({1'b0, req_row} >= {src_height_ff, 1'b0}) ||
                      ({1'b0, req_col} >= {src_width_ff, 1'b0});
   assign rd_accept = accept && (req_command == CMD_READ);
   assign wr_ok     = accept && (req_command == CMD_WRITE) &&
                      (req_row < src_height_ff) && (req_col < src_width_ff);

   assign wr_addr = ADDR_W'(ADDR_W'(req_row) * ADDR_W'(MAX_WIDTH)) + ADDR_W'(req_col);

   // neighbor order: center, row neighbor, column neighbor, diagonal
   always_comb begin
      case (state_ff)
         ST_C: begin
            rd_row = kr_ff;
            rd_col = kc_ff;
         end
         ST_RN: begin
            rd_row = nr_ff;
            rd_col = kc_ff;
         end
         ST_CN: begin
            rd_row = kr_ff;
            rd_col = nc_ff;
         end
         ST_D: begin
            rd_row = nr_ff;
            rd_col = nc_ff;
         end
         default: begin
            rd_row = kr_ff;
            rd_col = kc_ff;
         end
      endcase
   end

   assign rd_addr = ADDR_W'(ADDR_W'(rd_row) * ADDR_W'(MAX_WIDTH)) + ADDR_W'(rd_col);

   bu2xm_ram #(
      .WIDTH (PIX_W),
      .DEPTH (DEPTH)
   ) u_frame (
      .clock   (clock),
      .wr_en   (wr_ok),
      .wr_addr (wr_addr),
      .wr_data ({req_red_in, req_green_in, req_blue_in}),
      .rd_addr (rd_addr),
      .rd_data (rd_pix)
   );

   assign chan[0] = rd_pix[PIX_W-1 -: CHAN_W];
   assign chan[1] = rd_pix[2*CHAN_W-1 -: CHAN_W];
   assign chan[2] = rd_pix[CHAN_W-1:0];

   always_comb begin
      state_in     = state_ff;
      kr_in        = kr_ff;
      kc_in        = kc_ff;
      nr_in        = nr_ff;
      nc_in        = nc_ff;
      rsp_valid_in = 1'b0;
      rsp_err_in   = rsp_err_ff;
      for (int i = 0; i < 3; i++) begin
         acc_in[i] = acc_ff[i];
         out_in[i] = out_ff[i];
      end
      case (state_ff)
         ST_IDLE: begin
            if (rd_accept) begin
               if (coord_bad) begin
                  rsp_valid_in = 1'b1;
                  rsp_err_in   = 1'b1;
                  for (int i = 0; i < 3; i++) begin
                     out_in[i] = '0;
                  end
               end else begin
                  kr_in    = {1'b0, req_row[COORD_W-1:1]};
                  kc_in    = {1'b0, req_col[COORD_W-1:1]};
                  nr_in    = nbr_index(req_row, src_height_ff);
                  nc_in    = nbr_index(req_col, src_width_ff);
                  state_in = ST_C;
               end
            end
         end
         ST_C: begin
            state_in = ST_RN;
         end
         ST_RN: begin
            // center word arrives, weight 9
            for (int i = 0; i < 3; i++) begin
               acc_in[i] = {chan[i], 3'b000} + ACC_W'(chan[i]);
            end
            state_in = ST_CN;
         end
         ST_CN: begin
            for (int i = 0; i < 3; i++) begin
               acc_in[i] = acc_ff[i] + ACC_W'({chan[i], 1'b0}) + ACC_W'(chan[i]);
            end
            state_in = ST_D;
         end
         ST_D: begin
            for (int i = 0; i < 3; i++) begin
               acc_in[i] = acc_ff[i] + ACC_W'({chan[i], 1'b0}) + ACC_W'(chan[i]);
            end
            state_in = ST_LAST;
         end
         ST_LAST: begin
            // diagonal word, weight 1, then divide by 16
            for (int i = 0; i < 3; i++) begin
               acc_in[i] = acc_ff[i] + ACC_W'(chan[i]);
               out_in[i] = acc_in[i][ACC_W-1:4];
            end
            rsp_valid_in = 1'b1;
            rsp_err_in   = 1'b0;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         src_width_ff  <= WIDTH_RST;
         src_height_ff <= HEIGHT_RST;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SRC_WIDTH:  src_width_ff  <= clamp_dim(csr_data, MAX_WIDTH);
               CSR_SRC_HEIGHT: src_height_ff <= clamp_dim(csr_data, MAX_HEIGHT);
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      kr_ff      <= kr_in;
      kc_ff      <= kc_in;
      nr_ff      <= nr_in;
      nc_ff      <= nc_in;
      rsp_err_ff <= rsp_err_in;
      for (int i = 0; i < 3; i++) begin
         acc_ff[i] <= acc_in[i];
         out_ff[i] <= out_in[i];
      end
   end

   assign busy            = (state_ff != ST_IDLE);
   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_red_out     = out_ff[0];
   assign rsp_green_out   = out_ff[1];
   assign rsp_blue_out    = out_ff[2];
   assign rsp_coord_error = rsp_err_ff;

`include "assert_macros.svh"

   `ASSERT_CLK(a_rsp_source, clock, reset,
      rsp_valid_ff |-> ($past(state_ff) == ST_LAST) || ($past(rd_accept) && $past(coord_bad)))
   `ASSERT_NEVER(a_no_write_busy, clock, reset, wr_ok && busy)
   `ASSERT_CLK(a_bad_coord_fast, clock, reset,
      (rd_accept && coord_bad) |=> (!busy && rsp_valid_ff && rsp_err_ff))
   `ASSERT_CLK(a_err_zero, clock, reset,
      (rsp_valid_ff && rsp_err_ff) |-> (out_ff[0] == '0) && (out_ff[1] == '0) && (out_ff[2] == '0))

endmodule

`default_nettype wire
